// ===== src/tick_ordered_event_queue_assert.svh =====
// Assertion macros for the event queue RTL.
`ifndef TICK_ORDERED_EVENT_QUEUE_ASSERT_SVH
`define TICK_ORDERED_EVENT_QUEUE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, masked in reset.
`define TOEQ_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("queue check failed");

// Next-cycle implication, sampled on the rising clock edge, masked in reset.
`define TOEQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("queue check failed");

`endif

// ===== src/toeq_pkg.sv =====
// Package: types, codes and key compare for the tick ordered event queue.
package toeq_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = 5;

    localparam logic [1:0] OP_ENQ_AUTO  = 2'd0;
    localparam logic [1:0] OP_ENQ_GIVEN = 2'd1;
    localparam logic [1:0] OP_POP       = 2'd2;
    localparam logic [1:0] OP_POP_MATCH = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_DUP      = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_MISMATCH = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] tick;
        logic [31:0] seq;
        logic [15:0] payload_handle;
    } t_cmd;

    typedef struct packed {
        logic [2:0]       status;
        logic [31:0]      assigned_seq;
        logic             popped_valid;
        logic [31:0]      popped_tick;
        logic [31:0]      popped_seq;
        logic [15:0]      popped_payload;
        logic             front_valid;
        logic [31:0]      front_tick;
        logic [31:0]      front_seq;
        logic [15:0]      front_payload;
        logic [CNT_W-1:0] count;
        logic [31:0]      next_auto_seq;
    } t_result;

    typedef struct packed {
        logic        valid;
        logic [31:0] tick;
        logic [31:0] seq;
        logic [15:0] payload;
    } t_entry;

    typedef struct packed {
        logic [31:0] tick;
        logic [31:0] seq;
        logic [15:0] payload;
    } t_key;

    function automatic logic key_after(input logic [31:0] ta, input logic [31:0] sa,
                                       input logic [31:0] tb, input logic [31:0] sb);
        logic res;
        if (ta != tb) begin
            res = (ta > tb);
        end else begin
            res = (sa > sb);
        end
        return res;
    endfunction

endpackage

// ===== src/tick_ordered_event_queue.sv =====
// Top level: sorted event queue built as a chain of cells, with result register.
//
// Takes one command in every cycle (busy stays low) and gives its result in the
// next cycle, strobed by o_valid for exactly one cycle; the receiver cannot
// stall. All cells compare the broadcast key in parallel and shift by at most
// one place, so one insert or remove updates the whole chain at once.
`include "tick_ordered_event_queue_assert.svh"
module tick_ordered_event_queue
    import toeq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_cmd    i_cmd,
    output logic    o_valid,
    output t_result o_result
);

    localparam int LAST = CAPACITY - 1;

    t_entry                w_ent     [CAPACITY];
    t_entry                w_left    [CAPACITY];
    t_entry                w_right   [CAPACITY];
    logic   [CAPACITY-1:0] w_gt;
    logic   [CAPACITY-1:0] w_hit;
    logic   [CAPACITY-1:0] w_left_gt;
    logic   [CAPACITY-1:0] w_vld;
    t_key                  w_key;
    logic                  w_ins;
    logic                  w_pop;

    logic             r_valid;
    logic [2:0]       r_status;
    logic [31:0]      r_assigned;
    logic             r_popped;
    logic [31:0]      r_ptick;
    logic [31:0]      r_pseq;
    logic [15:0]      r_ppay;
    logic [CNT_W-1:0] r_count;
    logic [31:0]      r_auto;

    logic             n_valid;
    logic [2:0]       n_status;
    logic [31:0]      n_assigned;
    logic             n_popped;
    logic [CNT_W-1:0] n_count;
    logic [31:0]      n_auto;

    logic        is_enq;
    logic        dup;
    logic        full;
    logic        empty;
    logic        mismatch;
    logic [31:0] use_seq;

    assign busy = 1'b0;

    assign use_seq = (i_cmd.op == OP_ENQ_AUTO) ? r_auto : i_cmd.seq;
    assign w_key   = '{tick: i_cmd.tick, seq: use_seq, payload: i_cmd.payload_handle};

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            if (gi == 0) begin : g_head
                assign w_left[gi]    = '0;
                assign w_left_gt[gi] = 1'b0;
            end else begin : g_body
                assign w_left[gi]    = w_ent[gi-1];
                assign w_left_gt[gi] = w_gt[gi-1];
            end
            if (gi == LAST) begin : g_tail
                assign w_right[gi] = '0;
            end else begin : g_inner
                assign w_right[gi] = w_ent[gi+1];
            end
            assign w_vld[gi] = w_ent[gi].valid;

            toeq_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ins     (w_ins),
                .i_pop     (w_pop),
                .i_key     (w_key),
                .i_left    (w_left[gi]),
                .i_left_gt (w_left_gt[gi]),
                .i_right   (w_right[gi]),
                .o_ent     (w_ent[gi]),
                .o_gt      (w_gt[gi]),
                .o_hit     (w_hit[gi])
            );
        end
    endgenerate

    always_comb begin
        is_enq   = (i_cmd.op == OP_ENQ_AUTO) || (i_cmd.op == OP_ENQ_GIVEN);
        dup      = |w_hit;
        full     = w_ent[LAST].valid;
        empty    = !w_ent[0].valid;
        mismatch = (w_ent[0].tick != i_cmd.tick);

        w_ins = 1'b0;
        w_pop = 1'b0;

        n_valid    = start;
        n_status   = ST_OK;
        n_assigned = '0;
        n_popped   = 1'b0;
        n_count    = r_count;
        n_auto     = r_auto;

        if (is_enq) begin
            if (dup) begin
                n_status = ST_DUP;
            end else if (full) begin
                n_status = ST_FULL;
            end else begin
                w_ins      = start;
                n_assigned = use_seq;
            end
        end else if (empty) begin
            n_status = ST_EMPTY;
        end else if ((i_cmd.op == OP_POP_MATCH) && mismatch) begin
            n_status = ST_MISMATCH;
        end else begin
            w_pop    = start;
            n_popped = 1'b1;
        end

        if (w_ins) begin
            n_count = r_count + CNT_W'(1);
            if (i_cmd.op == OP_ENQ_AUTO) begin
                n_auto = r_auto + 32'd1;
            end
        end else if (w_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_count <= '0;
            r_auto  <= '0;
        end else begin
            r_valid <= n_valid;
            r_count <= n_count;
            r_auto  <= n_auto;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status   <= n_status;
        r_assigned <= n_assigned;
        r_popped   <= n_popped;
        r_ptick    <= n_popped ? w_ent[0].tick : 32'd0;
        r_pseq     <= n_popped ? w_ent[0].seq : 32'd0;
        r_ppay     <= n_popped ? w_ent[0].payload : 16'd0;
    end

    always_comb begin
        o_valid                 = r_valid;
        o_result.status         = r_status;
        o_result.assigned_seq   = r_assigned;
        o_result.popped_valid   = r_popped;
        o_result.popped_tick    = r_ptick;
        o_result.popped_seq     = r_pseq;
        o_result.popped_payload = r_ppay;
        o_result.front_valid    = w_ent[0].valid;
        o_result.front_tick     = w_ent[0].valid ? w_ent[0].tick : 32'd0;
        o_result.front_seq      = w_ent[0].valid ? w_ent[0].seq : 32'd0;
        o_result.front_payload  = w_ent[0].valid ? w_ent[0].payload : 16'd0;
        o_result.count          = r_count;
        o_result.next_auto_seq  = r_auto;
    end

    `TOEQ_ASSERT_NOW(a_count_matches_cells, 1'b1, r_count == CNT_W'($countones(w_vld)))
    `TOEQ_ASSERT_NOW(a_head_ordered, w_ent[0].valid && w_ent[1].valid,
        key_after(w_ent[1].tick, w_ent[1].seq, w_ent[0].tick, w_ent[0].seq))
    `TOEQ_ASSERT_NOW(a_single_shift, w_ins, !w_pop && !dup)
    `TOEQ_ASSERT_NEXT(a_insert_counts, w_ins, r_count == $past(r_count) + CNT_W'(1))
    `TOEQ_ASSERT_NEXT(a_auto_advance, w_ins && (i_cmd.op == OP_ENQ_AUTO),
        r_auto == $past(r_auto) + 32'd1)

endmodule

// ===== src/toeq_cell.sv =====
// One cell of the sorted chain: holds one event, shifts on insert or pop.
module toeq_cell
    import toeq_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_ins,
    input  logic   i_pop,
    input  t_key   i_key,
    input  t_entry i_left,
    input  logic   i_left_gt,
    input  t_entry i_right,
    output t_entry o_ent,
    output logic   o_gt,
    output logic   o_hit
);

    logic        r_valid;
    logic [31:0] r_tick;
    logic [31:0] r_seq;
    logic [15:0] r_payload;
    t_entry      n_ent;

    always_comb begin
        o_ent = '{valid: r_valid, tick: r_tick, seq: r_seq, payload: r_payload};
        o_gt  = !r_valid || key_after(r_tick, r_seq, i_key.tick, i_key.seq);
        o_hit = r_valid && (r_seq == i_key.seq);
    end

    always_comb begin
        n_ent = o_ent;
        if (i_ins && o_gt) begin
            if (i_left_gt) begin
                n_ent = i_left;
            end else begin
                n_ent = '{valid: 1'b1, tick: i_key.tick, seq: i_key.seq,
                          payload: i_key.payload};
            end
        end else if (i_pop) begin
            n_ent = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_ent.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tick    <= n_ent.tick;
        r_seq     <= n_ent.seq;
        r_payload <= n_ent.payload;
    end

endmodule
